/* design/bae_pkg.sv */
// ----------------------------------------------------------------------------
// bae_pkg
// Shared types and constants of the bit array engine.
// ----------------------------------------------------------------------------
package bae_pkg;

  localparam int unsigned DefNumWords  = 64;
  localparam int unsigned DefWordBits  = 64;
  localparam int unsigned FuncW        = 3;
  localparam int unsigned IdxW         = 12;
  localparam int unsigned LenW         = 13;
  localparam int unsigned NumBitsReset = 4096;

  typedef enum logic [FuncW-1:0] {
    FnSetBit = 3'd0,
    FnClrBit = 3'd1,
    FnTglBit = 3'd2,
    FnRdBit  = 3'd3,
    FnSetRun = 3'd4,
    FnClrRun = 3'd5,
    FnTglRun = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    OpSet = 2'd0,
    OpClr = 2'd1,
    OpTgl = 2'd2,
    OpRd  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StDivQ,
    StDivR,
    StRead,
    StWrite,
    StDone
  } state_e;

endpackage

/* design/bae_ram.sv */
// ----------------------------------------------------------------------------
// bae_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bae_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/bit_array_engine.sv */
// ----------------------------------------------------------------------------
// bit_array_engine
// Bit store with single-bit set, clear, toggle and read requests and run set, clear and toggle requests.
// ----------------------------------------------------------------------------
// After reset the store is swept to zero, one word a cycle, so no item is
// taken until the sweep is done. Each item then passes through setup
// (accept, then quotient, then remainder of the start position by WORD_BITS,
// each on its own multiplier), a registered memory read and a modify and
// write back for each word touched, and a final step that hands the result
// to the output register once that register is free. A single-bit request
// touches one word; a run of length L starting at offset o touches
// ceil((o + L) / WORD_BITS) words. Rejected and empty requests go from accept
// straight to the final step. The next item is accepted while a result waits.
// ----------------------------------------------------------------------------
module bit_array_engine #(
  parameter int unsigned NUM_WORDS = bae_pkg::DefNumWords,
  parameter int unsigned WORD_BITS = bae_pkg::DefWordBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bae_pkg::LenW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [bae_pkg::FuncW-1:0] func_i,
  input  logic [bae_pkg::IdxW-1:0]  bit_index_i,
  input  logic [bae_pkg::LenW-1:0]  run_length_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      bit_value_o,
  output logic                      range_error_o
);

  localparam int unsigned IdxW   = bae_pkg::IdxW;
  localparam int unsigned LenW   = bae_pkg::LenW;
  localparam int unsigned AW     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned OffW   = $clog2(WORD_BITS);
  localparam int unsigned CntW   = OffW + 1;
  localparam int unsigned Cap    = NUM_WORDS * WORD_BITS;
  localparam int unsigned CapSat = (Cap > 8191) ? 8191 : Cap;
  localparam int unsigned DivSh  = IdxW + 6;
  localparam int unsigned DivMul = ((1 << DivSh) + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ProdW  = DivSh + IdxW;

  bae_pkg::state_e state_q, state_d;

  logic [LenW-1:0]      num_bits_q;
  logic [AW-1:0]        clr_q;
  bae_pkg::op_e         op_q;
  logic                 err_q;
  logic                 val_q;
  logic [IdxW-1:0]      idx_q;
  logic [IdxW-1:0]      quo_q;
  logic [AW-1:0]        word_q;
  logic [OffW-1:0]      off_q;
  logic [LenW-1:0]      rem_q;
  logic                 out_valid_q;
  logic                 bit_value_q;
  logic                 range_error_q;

  logic                 accept;
  logic                 is_single;
  logic                 is_run;
  logic [LenW-1:0]      limit;
  logic [LenW:0]        run_end;
  logic                 req_err;
  logic                 req_noop;

  logic [ProdW-1:0]     prod;
  logic [IdxW-1:0]      base;
  logic [CntW-1:0]      avail;
  logic [CntW-1:0]      take;
  logic [WORD_BITS-1:0] ones;
  logic [WORD_BITS-1:0] mask;
  logic                 tail_word;
  logic                 out_load;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [WORD_BITS-1:0] mem_rdata;

  // request decode and range check
  assign is_single = (func_i == bae_pkg::FnSetBit) || (func_i == bae_pkg::FnClrBit) ||
                     (func_i == bae_pkg::FnTglBit) || (func_i == bae_pkg::FnRdBit);
  assign is_run    = (func_i == bae_pkg::FnSetRun) || (func_i == bae_pkg::FnClrRun) ||
                     (func_i == bae_pkg::FnTglRun);
  assign limit     = (num_bits_q > LenW'(CapSat)) ? LenW'(CapSat) : num_bits_q;
  assign run_end   = {2'b00, bit_index_i} + {1'b0, run_length_i};
  assign req_err   = (is_single && ({1'b0, bit_index_i} >= limit)) ||
                     (is_run && (run_length_i != '0) && (run_end > {1'b0, limit}));
  assign req_noop  = req_err || !(is_single || is_run) ||
                     (is_run && (run_length_i == '0));
  assign accept    = in_valid_i && in_ready_o;

  // word index and offset of the start position
  assign prod = ProdW'(idx_q) * ProdW'(DivMul);
  assign base = quo_q * IdxW'(WORD_BITS);

  // run mask within the current word
  assign avail     = CntW'(WORD_BITS) - {1'b0, off_q};
  assign take      = (rem_q < LenW'(avail)) ? rem_q[CntW-1:0] : avail;
  assign ones      = {WORD_BITS{1'b1}} >> (CntW'(WORD_BITS) - take);
  assign mask      = ones << off_q;
  assign tail_word = (rem_q == LenW'(take));
  assign out_load  = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bae_pkg::StClear: begin
        if (clr_q == AW'(NUM_WORDS - 1)) state_d = bae_pkg::StIdle;
      end
      bae_pkg::StIdle: begin
        if (accept) state_d = req_noop ? bae_pkg::StDone : bae_pkg::StDivQ;
      end
      bae_pkg::StDivQ:  state_d = bae_pkg::StDivR;
      bae_pkg::StDivR:  state_d = bae_pkg::StRead;
      bae_pkg::StRead:  state_d = bae_pkg::StWrite;
      bae_pkg::StWrite: state_d = tail_word ? bae_pkg::StDone : bae_pkg::StRead;
      bae_pkg::StDone: begin
        if (out_load) state_d = bae_pkg::StIdle;
      end
      default: state_d = bae_pkg::StIdle;
    endcase
  end

  // outputs and memory control
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = word_q;
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    unique case (state_q)
      bae_pkg::StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      bae_pkg::StIdle: in_ready_o = 1'b1;
      bae_pkg::StRead: mem_re = 1'b1;
      bae_pkg::StWrite: begin
        mem_we = (op_q != bae_pkg::OpRd);
        unique case (op_q)
          bae_pkg::OpSet: mem_wdata = mem_rdata | mask;
          bae_pkg::OpClr: mem_wdata = mem_rdata & ~mask;
          bae_pkg::OpTgl: mem_wdata = mem_rdata ^ mask;
          bae_pkg::OpRd:  mem_wdata = mem_rdata;
          default:        mem_wdata = mem_rdata;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bae_pkg::StClear;
      clr_q       <= '0;
      num_bits_q  <= LenW'(bae_pkg::NumBitsReset);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == bae_pkg::StClear) clr_q <= clr_q + AW'(1);
      if (cfg_we_i) num_bits_q <= cfg_wdata_i;
      if (state_q == bae_pkg::StDone && out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      bae_pkg::StIdle: begin
        if (accept) begin
          op_q  <= bae_pkg::op_e'(func_i[1:0]);
          err_q <= req_err;
          val_q <= 1'b0;
          idx_q <= bit_index_i;
          rem_q <= is_run ? run_length_i : LenW'(1);
        end
      end
      bae_pkg::StDivQ: quo_q <= prod[ProdW-1:DivSh];
      bae_pkg::StDivR: begin
        word_q <= AW'(quo_q);
        off_q  <= OffW'(idx_q - base);
      end
      bae_pkg::StWrite: begin
        if (op_q == bae_pkg::OpRd) val_q <= mem_rdata[off_q];
        rem_q  <= rem_q - LenW'(take);
        word_q <= word_q + AW'(1);
        off_q  <= '0;
      end
      bae_pkg::StDone: begin
        if (out_load) begin
          bit_value_q   <= val_q;
          range_error_q <= err_q;
        end
      end
      default: ;
    endcase
  end

  bae_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NUM_WORDS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(word_q),
    .rdata_o(mem_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign bit_value_o   = bit_value_q;
  assign range_error_o = range_error_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("item accepted while busy");

  a_err_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(range_error_o && bit_value_o))
    else $error("rejected item returned a bit");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bae_pkg::StIdle) |-> !mem_we)
    else $error("store written while idle");

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({1'b0, mem_waddr} < (AW + 1)'(NUM_WORDS)))
    else $error("store write beyond last word");

endmodule
